/* rtl/chis_pkg.sv */
// Package for the chained hash table: field widths, status and operation codes,
// parameter defaults, and the command/status structs between controller and datapath.
// Depends on nothing.
package chis_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned KeyW    = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 5;

  // Defaults for the top-level parameters.
  localparam int unsigned BucketsDef   = 7;
  localparam int unsigned PoolNodesDef = 16;
  localparam int unsigned KeyBitsDef   = 8;

  // Operation codes of the func field.
  localparam logic FuncInsert = 1'b0;
  localparam logic FuncSearch = 1'b1;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_INSERTED = 2'd0,
    ST_FOUND    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;        // capture the input transaction and read its bucket head
    logic    insert;      // link a new node at the bucket head (ignored when full)
    logic    start;       // read the head node of the chain
    logic    step;        // read the node that the current link points to
    logic    res_set;     // load the result register
    status_e res_status;  // status to load
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_search;
    logic full;
    logic head_empty;
    logic key_match;
    logic link_empty;
  } stat_t;

endpackage

/* rtl/chis_in_if.sv */
// Input channel of the chained hash table: valid/ready handshake with func and key.
// Depends on chis_pkg.
interface chis_in_if
  import chis_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            func;
  logic [KeyW-1:0] key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

/* rtl/chis_out_if.sv */
// Result channel of the chained hash table: valid/ready handshake with status and position.
// Depends on chis_pkg.
interface chis_out_if
  import chis_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [PosW-1:0]    position;

  modport source (output valid, output status, output position, input ready);
  modport sink   (input valid, input status, input position, output ready);
endinterface

/* rtl/chis_ctrl.sv */
// Controller of the chained hash table: one-hot state machine that sequences
// insert and chain walk. Depends on chis_pkg.
module chis_ctrl
  import chis_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WALK = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = ST_NOTFOUND;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        // Head of the bucket is available now.
        if (!stat_i.is_search) begin
          cmd_o.insert     = 1'b1;
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = stat_i.full ? ST_FULL : ST_INSERTED;
          state_d          = S_OUT;
        end else if (stat_i.head_empty) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_NOTFOUND;
          state_d          = S_OUT;
        end else begin
          cmd_o.start = 1'b1;
          state_d     = S_WALK;
        end
      end
      S_WALK: begin
        // One chain node is compared per cycle.
        if (stat_i.key_match) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_FOUND;
          state_d          = S_OUT;
        end else if (stat_i.link_empty) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_NOTFOUND;
          state_d          = S_OUT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

/* rtl/chis_dp.sv */
// Datapath of the chained hash table: bucket table, node pool memories, pool count,
// chain pointer and result register. Depends on chis_pkg.
module chis_dp
  import chis_pkg::*;
#(
  parameter int unsigned BUCKETS    = BucketsDef,
  parameter int unsigned POOL_NODES = PoolNodesDef,
  parameter int unsigned KEY_BITS   = KeyBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_func_i,
  input  logic [KeyW-1:0]    in_key_i,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  output logic [StatusW-1:0] status_o,
  output logic [PosW-1:0]    position_o
);

  // Stored key width, bucket index width, pointer (index + 1) and pool index widths.
  localparam int unsigned KW = (KEY_BITS < KeyW) ? KEY_BITS : KeyW;
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned PW = $clog2(POOL_NODES + 1);
  localparam int unsigned IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned NK = 2 ** KW;

  // Bucket of every possible key, fixed at elaboration.
  logic [BW-1:0] mod_tbl [NK];
  for (genvar g = 0; g < NK; g++) begin : g_mod
    assign mod_tbl[g] = BW'(g % BUCKETS);
  end

  logic [KW-1:0] key_in;
  logic [BW-1:0] bkt_in;
  assign key_in = in_key_i[KW-1:0];
  assign bkt_in = mod_tbl[key_in];

  // Captured transaction.
  logic          func_q;
  logic [KW-1:0] key_q;
  logic [BW-1:0] bucket_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= in_func_i;
      key_q    <= key_in;
      bucket_q <= bkt_in;
    end
  end

  // Pool fill count.
  logic [PW-1:0] used_q;
  logic          full;
  logic          do_ins;
  assign full   = (used_q == PW'(POOL_NODES));
  assign do_ins = cmd_i.insert && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (do_ins) begin
      used_q <= used_q + PW'(1);
    end
  end

  // Bucket heads: memory plus one valid bit per bucket; an invalid bucket is empty.
  logic [PW-1:0]      head_mem [BUCKETS];
  logic [BUCKETS-1:0] head_vld_q;
  logic [PW-1:0]      head_rd_q;
  logic               head_vld_rd_q;
  logic [PW-1:0]      head;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      head_rd_q <= head_mem[bkt_in];
    end
    if (do_ins) begin
      head_mem[bucket_q] <= used_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q    <= '0;
      head_vld_rd_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        head_vld_rd_q <= head_vld_q[bkt_in];
      end
      if (do_ins) begin
        head_vld_q[bucket_q] <= 1'b1;
      end
    end
  end

  assign head = head_vld_rd_q ? head_rd_q : '0;

  // Node pool: key and link memories with registered read.
  logic [KW-1:0] node_key_mem  [POOL_NODES];
  logic [PW-1:0] node_link_mem [POOL_NODES];
  logic [KW-1:0] nkey_rd_q;
  logic [PW-1:0] nlink_rd_q;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] rd_idx;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;

  assign rd_ptr  = cmd_i.start ? head : nlink_rd_q;
  assign rd_idx  = rd_ptr - PW'(1);
  assign rd_addr = IW'(rd_idx);
  assign wr_addr = IW'(used_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start || cmd_i.step) begin
      nkey_rd_q  <= node_key_mem[rd_addr];
      nlink_rd_q <= node_link_mem[rd_addr];
    end
    if (do_ins) begin
      node_key_mem[wr_addr]  <= key_q;
      node_link_mem[wr_addr] <= head;
    end
  end

  // Chain position of the node being compared.
  logic [PosW-1:0] pos_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pos_q <= PosW'(1);
    end else if (cmd_i.step) begin
      pos_q <= pos_q + PosW'(1);
    end
  end

  // Result register.
  status_e         status_q;
  logic [PosW-1:0] position_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      status_q   <= cmd_i.res_status;
      position_q <= (cmd_i.res_status == ST_FOUND) ? pos_q : '0;
    end
  end

  assign status_o   = status_q;
  assign position_o = position_q;

  // Status toward the controller.
  always_comb begin
    stat_o.is_search  = (func_q == FuncSearch);
    stat_o.full       = full;
    stat_o.head_empty = (head == '0);
    stat_o.key_match  = (nkey_rd_q == key_q);
    stat_o.link_empty = (nlink_rd_q == '0);
  end

endmodule

/* rtl/chained_hash_insert_search.sv */
// Chained hash table with insert and search over a fixed node pool.
// The result of an insert is set in the EXEC state; a search walks the chain in the WALK state
// (one node compared per cycle) until it finds the key or reaches the end of the chain.
// One transaction at a time: the next is accepted the cycle after the result is taken.
// Reset clears the bucket valid bits and the pool count at once; no clearing pass.
module chained_hash_insert_search
  import chis_pkg::*;
#(
  parameter int unsigned BUCKETS    = BucketsDef,
  parameter int unsigned POOL_NODES = PoolNodesDef,
  parameter int unsigned KEY_BITS   = KeyBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  chis_in_if.sink    in_i,
  chis_out_if.source out_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencing of insert and chain walk.
  chis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Storage and result.
  chis_dp #(
    .BUCKETS    (BUCKETS),
    .POOL_NODES (POOL_NODES),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_func_i  (in_i.func),
    .in_key_i   (in_i.key),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .status_o   (out_o.status),
    .position_o (out_o.position)
  );

endmodule

/* bench/chis_hash_checker.sv */
// Checker for the chained hash table: watches both channels, keeps its own copy of the
// bucket heads and node pool, predicts every result and compares it field by field.
// Depends on chis_pkg, chis_in_if and chis_out_if.
module chis_hash_checker
  import chis_pkg::*;
#(
  parameter int unsigned BUCKETS    = BucketsDef,
  parameter int unsigned POOL_NODES = PoolNodesDef,
  parameter int unsigned KEY_BITS   = KeyBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  chis_in_if   in_mon_i,
  chis_out_if  out_mon_i,
  output int   fail_count_o,
  output int   pending_o
);

  // Links hold pool index + 1, so they need room for POOL_NODES itself.
  localparam int unsigned PtrW = $clog2(POOL_NODES + 1);
  localparam logic [KeyW-1:0] KeyMask =
    (KEY_BITS >= KeyW) ? {KeyW{1'b1}} : KeyW'((1 << KEY_BITS) - 1);

  typedef struct packed {
    status_e         status;
    logic [PosW-1:0] position;
  } hash_result_t;

  // Shadow copy of the table.
  logic [PtrW-1:0] chain_head [BUCKETS];
  logic [KeyW-1:0] pool_key   [POOL_NODES];
  logic [PtrW-1:0] pool_next  [POOL_NODES];
  logic [PtrW-1:0] pool_taken;

  hash_result_t result_q [$];

  // Applies one operation to the shadow table and returns the result it should produce.
  function automatic hash_result_t link_or_walk(input logic func, input logic [KeyW-1:0] key_in);
    logic [KeyW-1:0] key;
    int unsigned     bucket;
    int unsigned     ptr;
    int unsigned     pos;
    int unsigned     visits;
    logic            done;
    hash_result_t    res;
    key          = key_in & KeyMask;
    bucket       = key % BUCKETS;
    res.status   = ST_NOTFOUND;
    res.position = '0;
    if (func == FuncInsert) begin
      if (pool_taken >= POOL_NODES) begin
        res.status = ST_FULL;
      end else begin
        pool_key[pool_taken]  = key;
        pool_next[pool_taken] = chain_head[bucket];
        chain_head[bucket]    = pool_taken + 1'b1;
        pool_taken            = pool_taken + 1'b1;
        res.status            = ST_INSERTED;
      end
    end else begin
      // Walk from the head; the newest node of a duplicate key is met first.
      ptr    = chain_head[bucket];
      pos    = 0;
      visits = 0;
      done   = 1'b0;
      while (!done && visits < POOL_NODES) begin
        if (ptr == 0 || ptr > POOL_NODES) begin
          done = 1'b1;
        end else begin
          pos++;
          if (pool_key[ptr-1] == key) begin
            res.status   = ST_FOUND;
            res.position = PosW'(pos);
            done         = 1'b1;
          end else begin
            ptr = pool_next[ptr-1];
          end
        end
        visits++;
      end
    end
    return res;
  endfunction

  // Predict on every accepted operation, compare on every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    hash_result_t exp_res;
    if (!rst_ni) begin
      for (int b = 0; b < BUCKETS; b++) chain_head[b] = '0;
      pool_taken   = '0;
      result_q     = {};
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        result_q.push_back(link_or_walk(in_mon_i.func, in_mon_i.key));
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result transaction: status %0d, position %0d",
                 out_mon_i.status, out_mon_i.position);
          fail_count_o++;
        end else begin
          exp_res = result_q.pop_front();
          if (out_mon_i.status !== exp_res.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   exp_res.status, out_mon_i.status);
            fail_count_o++;
          end
          if (out_mon_i.position !== exp_res.position) begin
            $error("position mismatch: expected %0d, actual %0d",
                   exp_res.position, out_mon_i.position);
            fail_count_o++;
          end
        end
      end
      pending_o = result_q.size();
    end
  end

endmodule

/* bench/chained_hash_insert_search_tb.sv */
// Testbench top for the chained hash table: builds the operation stream, drives the input
// channel, paces the result channel, and gives the verdict from the checker's counts.
// Depends on chis_pkg, chis_in_if, chis_out_if, chis_hash_checker and the block itself.
module chained_hash_insert_search_tb;
  import chis_pkg::*;

  localparam int unsigned Buckets       = BucketsDef;
  localparam int unsigned PoolNodes     = PoolNodesDef;
  localparam int          RandomOps     = 900;
  localparam int          HoldResult    = 200;
  localparam int          HoldCycles    = 80;
  localparam int          TailCycles    = 40;
  localparam int          WatchdogLimit = 2000;

  typedef struct packed {
    logic            func;
    logic [KeyW-1:0] key;
  } hash_op_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int fail_count;
  int pending;

  hash_op_t        op_q [$];
  logic [KeyW-1:0] stored_keys [$];

  chis_in_if  in_if ();
  chis_out_if out_if ();

  always #2 clk_i = ~clk_i;

  chained_hash_insert_search #(
    .BUCKETS    (Buckets),
    .POOL_NODES (PoolNodes),
    .KEY_BITS   (KeyBitsDef)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  chis_hash_checker #(
    .BUCKETS    (Buckets),
    .POOL_NODES (PoolNodes),
    .KEY_BITS   (KeyBitsDef)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_if),
    .out_mon_i    (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Ends the run when no transaction moves on either channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int       inserts;
    int       pick;
    int       total;
    hash_op_t op;

    in_if.valid  = 1'b0;
    in_if.func   = FuncInsert;
    in_if.key    = '0;
    out_if.ready = 1'b0;

    // Directed part: empty-bucket miss, key extremes, a collision chain in bucket zero with
    // a duplicate key at its head, hits at several depths, misses in empty and busy buckets.
    op_q.push_back('{FuncSearch, 8'd5});
    op_q.push_back('{FuncInsert, 8'd0});
    op_q.push_back('{FuncInsert, 8'd255});
    op_q.push_back('{FuncInsert, 8'd7});
    op_q.push_back('{FuncInsert, 8'd14});
    op_q.push_back('{FuncInsert, 8'd0});
    op_q.push_back('{FuncSearch, 8'd0});
    op_q.push_back('{FuncSearch, 8'd14});
    op_q.push_back('{FuncSearch, 8'd7});
    op_q.push_back('{FuncSearch, 8'd255});
    op_q.push_back('{FuncSearch, 8'd28});
    op_q.push_back('{FuncSearch, 8'd254});
    op_q.push_back('{FuncSearch, 8'd3});
    stored_keys = '{8'd0, 8'd255, 8'd7, 8'd14};
    inserts     = 5;

    // Random part: inserts lean on bucket zero to grow a long chain until the pool runs
    // out, later inserts hit the full table, and most searches ask for stored keys.
    for (int i = 0; i < RandomOps; i++) begin
      pick = $urandom_range(0, 99);
      if ((inserts < PoolNodes && pick < 25) || (inserts >= PoolNodes && pick < 8)) begin
        op.func = FuncInsert;
        pick    = $urandom_range(0, 99);
        if (pick < 50) begin
          op.key = KeyW'(7 * $urandom_range(0, 36));
        end else if (pick < 75) begin
          op.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        end else begin
          op.key = KeyW'($urandom_range(0, 255));
        end
        if (inserts < PoolNodes) stored_keys.push_back(op.key);
        inserts++;
      end else begin
        op.func = FuncSearch;
        pick    = $urandom_range(0, 99);
        if (pick < 60) begin
          op.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        end else if (pick < 70) begin
          op.key = KeyW'(7 * $urandom_range(0, 36));
        end else begin
          op.key = KeyW'($urandom_range(0, 255));
        end
      end
      op_q.push_back(op);
    end
    total = op_q.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    fork
      // Sender: random gaps between transactions, with calm stretches without gaps.
      begin
        int   gap;
        logic calm;
        calm = 1'b0;
        for (int i = 0; i < total; i++) begin
          if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
          gap = calm ? 0 : $urandom_range(0, 5);
          @(negedge clk_i);
          if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk_i);
          end
          in_if.valid <= 1'b1;
          in_if.func  <= op_q[i].func;
          in_if.key   <= op_q[i].key;
          do @(posedge clk_i); while (!in_if.ready);
        end
        @(negedge clk_i);
        in_if.valid <= 1'b0;
      end
      // Receiver: random stalls per result, and one long hold-off that backs up the input.
      begin
        int   stall;
        logic calm;
        calm = 1'b0;
        for (int k = 0; k < total; k++) begin
          if (k % 50 == 0) calm = ($urandom_range(0, 3) == 0);
          stall = (k == HoldResult) ? HoldCycles : (calm ? 0 : $urandom_range(0, 5));
          @(negedge clk_i);
          if (stall > 0) begin
            out_if.ready <= 1'b0;
            repeat (stall) @(negedge clk_i);
          end
          out_if.ready <= 1'b1;
          do @(posedge clk_i); while (!out_if.valid);
        end
      end
    join

    // Ready stays high, so any stray result still reaches the checker.
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
